// ===== sv/deadline_timer_queue_top_macros.svh =====
// Assertion macros shared by the timer queue RTL.
`ifndef DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DTQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, checked outside reset.
`define DTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ===== sv/dtq_pkg.sv =====
// Package with constants and types of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;
  localparam int TIMERS      = 16;
  localparam int TICK_BITS   = 32;
  localparam int ID_W        = 4;
  localparam int DUR_W       = 31;
  localparam int SEQ_W       = 32;
  localparam int REQ_W       = 2;
  localparam int MAX_RESULTS = 16;
  localparam int SCAN_W      = $clog2(TIMERS + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam logic [TICK_BITS-1:0] HALF_RANGE = {1'b0, {(TICK_BITS-1){1'b1}}};

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

  typedef struct packed {
    logic                 v;
    logic [ID_W-1:0]      id;
    logic [TICK_BITS-1:0] late;
    logic [SEQ_W-1:0]     age;
  } cand_t;

  typedef struct packed {
    logic                 arm;
    logic                 stop;
    logic                 fire;
    logic [ID_W-1:0]      id;
    logic [TICK_BITS-1:0] deadline;
    logic [SEQ_W-1:0]     order;
    logic                 shift;
    logic                 clr;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ===== sv/dtq_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface dtq_in_if;
  logic                       valid;
  logic                       ready;
  logic [dtq_pkg::REQ_W-1:0]  req_type;
  logic [dtq_pkg::ID_W-1:0]   timer_id;
  logic [dtq_pkg::DUR_W-1:0]  duration;
  modport source (output valid, req_type, timer_id, duration, input ready);
  modport sink (input valid, req_type, timer_id, duration, output ready);
endinterface

interface dtq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          fired;
  logic [dtq_pkg::ID_W-1:0]      fired_id;
  logic [dtq_pkg::TICK_BITS-1:0] now_tick;
  logic                          last;
  modport source (output valid, fired, fired_id, now_tick, last, input ready);
  modport sink (input valid, fired, fired_id, now_tick, last, output ready);
endinterface
`default_nettype wire

// ===== sv/dtq_cell.sv =====
// One timer cell: holds a timer and merges it into the passing best candidate.
`timescale 1ns / 1ps
`default_nettype none
module dtq_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [dtq_pkg::ID_W-1:0]      my_id,
  input  wire dtq_pkg::cell_ctrl_t           ctl,
  input  wire logic [dtq_pkg::TICK_BITS-1:0] tick,
  input  wire logic [dtq_pkg::SEQ_W-1:0]     seq,
  input  wire dtq_pkg::cand_t                cin,
  output dtq_pkg::cand_t                     cout
);
  logic                          armed_r;
  logic [dtq_pkg::TICK_BITS-1:0] dl_r;
  logic [dtq_pkg::SEQ_W-1:0]     ord_r;
  dtq_pkg::cand_t                cand_r;
  logic [dtq_pkg::TICK_BITS-1:0] late;
  logic [dtq_pkg::SEQ_W-1:0]     age;
  logic                          better;
  logic                          match;

  always_comb begin
    late   = tick - dl_r;
    age    = seq - ord_r;
    match  = (ctl.id == my_id);
    // Strict compares keep the lower-index candidate on a full tie.
    better = armed_r && (late < dtq_pkg::HALF_RANGE) &&
             (!cin.v || (late > cin.late) || ((late == cin.late) && (age > cin.age)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      cand_r.v <= 1'b0;
    end else begin
      if (ctl.arm && match) begin
        armed_r <= 1'b1;
        dl_r    <= ctl.deadline;
        ord_r   <= ctl.order;
      end else if ((ctl.stop || ctl.fire) && match) begin
        armed_r <= 1'b0;
      end
      if (ctl.clr) begin
        cand_r.v <= 1'b0;
      end else if (ctl.shift) begin
        cand_r.v <= better ? 1'b1 : cin.v;
      end
      if (ctl.shift) begin
        cand_r.id   <= better ? my_id : cin.id;
        cand_r.late <= better ? late : cin.late;
        cand_r.age  <= better ? age : cin.age;
      end
    end
  end

  assign cout = cand_r;
endmodule
`default_nettype wire

// ===== sv/deadline_timer_queue_top.sv =====
// Top level of the deadline timer queue: request decode, scan control, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "deadline_timer_queue_top_macros.svh"
// A start or stop request gives one result beat. A tick searches the row of
// timer cells for the most overdue expired timer; the best candidate moves one
// cell per cycle. A new request is taken only once every result beat of the
// previous one has been delivered.
module deadline_timer_queue_top (
  input wire logic  clk,
  input wire logic  rst_n,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [dtq_pkg::TICK_BITS-1:0] tick_r;
  logic [dtq_pkg::SEQ_W-1:0]     seq_r;
  logic [dtq_pkg::SCAN_W-1:0]    scan_r;
  logic [dtq_pkg::CNT_W-1:0]     n_r;
  logic                          pend_v_r;
  logic [dtq_pkg::ID_W-1:0]      pend_id_r;
  logic                          flush_r;
  logic                          rescan_r;
  logic                          out_valid_r;
  logic                          out_fired_r;
  logic [dtq_pkg::ID_W-1:0]      out_id_r;
  logic                          out_last_r;

  dtq_pkg::cell_ctrl_t ctl;
  dtq_pkg::cand_t      chain [dtq_pkg::TIMERS+1];
  dtq_pkg::cand_t      best;
  logic accept, scan_end, found, id_ok, out_take;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;
  assign scan_end = (state_r == S_SCAN) && (scan_r == dtq_pkg::SCAN_W'(dtq_pkg::TIMERS));
  assign best     = chain[dtq_pkg::TIMERS];
  assign found    = scan_end && best.v;
  assign id_ok    = (32'(in_ch.timer_id) < dtq_pkg::TIMERS);

  always_comb begin
    ctl.arm      = accept && (in_ch.req_type == dtq_pkg::REQ_START) && id_ok;
    ctl.stop     = accept && (in_ch.req_type == dtq_pkg::REQ_STOP);
    ctl.fire     = found;
    ctl.id       = found ? best.id : in_ch.timer_id;
    ctl.deadline = tick_r + dtq_pkg::TICK_BITS'(in_ch.duration);
    ctl.order    = seq_r;
    ctl.shift    = (state_r == S_SCAN);
    ctl.clr      = (accept && (in_ch.req_type == dtq_pkg::REQ_TICK)) ||
                   (scan_end && found && (n_r + 1'b1 < dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS))
                    && !pend_v_r) ||
                   (out_take && rescan_r);
  end

  assign chain[0] = '0;
  for (genvar i = 0; i < dtq_pkg::TIMERS; i++) begin : g_cell
    dtq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .my_id (dtq_pkg::ID_W'(i)),
      .ctl   (ctl),
      .tick  (tick_r),
      .seq   (seq_r),
      .cin   (chain[i]),
      .cout  (chain[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = (in_ch.req_type == dtq_pkg::REQ_TICK) ? S_SCAN : S_EMIT;
      S_SCAN: if (scan_end) begin
        if (found && !pend_v_r && (n_r + 1'b1 < dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS))) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: if (out_take && !flush_r) state_nxt = rescan_r ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      seq_r       <= '0;
      scan_r      <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      flush_r     <= 1'b0;
      rescan_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.clr) begin
        scan_r <= '0;
      end else if (state_r == S_SCAN) begin
        scan_r <= scan_r + 1'b1;
      end
      if (ctl.arm) seq_r <= seq_r + 1'b1;
      if (accept) begin
        n_r      <= '0;
        rescan_r <= 1'b0;
        flush_r  <= 1'b0;
        if (in_ch.req_type == dtq_pkg::REQ_TICK) begin
          tick_r <= tick_r + 1'b1;
        end else begin
          out_valid_r <= 1'b1;
          out_fired_r <= 1'b0;
          out_id_r    <= '0;
          out_last_r  <= 1'b1;
        end
      end
      if (scan_end) begin
        if (found) begin
          n_r <= n_r + 1'b1;
          if (pend_v_r) begin
            // The held hit goes out now; the new hit waits until the next search shows
            // whether it is the final one, or, at the result limit, follows as the final one.
            out_valid_r <= 1'b1;
            out_fired_r <= 1'b1;
            out_id_r    <= pend_id_r;
            out_last_r  <= 1'b0;
            pend_id_r   <= best.id;
            if (n_r + 1'b1 < dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS)) begin
              rescan_r <= 1'b1;
            end else begin
              flush_r <= 1'b1;
            end
          end else if (n_r + 1'b1 < dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS)) begin
            pend_v_r  <= 1'b1;
            pend_id_r <= best.id;
          end else begin
            out_valid_r <= 1'b1;
            out_fired_r <= 1'b1;
            out_id_r    <= best.id;
            out_last_r  <= 1'b1;
            rescan_r    <= 1'b0;
          end
        end else begin
          out_valid_r <= 1'b1;
          out_fired_r <= pend_v_r;
          out_id_r    <= pend_v_r ? pend_id_r : '0;
          out_last_r  <= 1'b1;
          pend_v_r    <= 1'b0;
          rescan_r    <= 1'b0;
        end
      end
      if (out_take) begin
        if (flush_r) begin
          out_fired_r <= 1'b1;
          out_id_r    <= pend_id_r;
          out_last_r  <= 1'b1;
          pend_v_r    <= 1'b0;
          flush_r     <= 1'b0;
          rescan_r    <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
          rescan_r    <= 1'b0;
        end
      end
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.fired    = out_fired_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.now_tick = tick_r;
  assign out_ch.last     = out_last_r;

  `DTQ_ASSERT_NOW(a_ready_free, in_ch.ready, !out_valid_r && !pend_v_r)
  `DTQ_ASSERT_NOW(a_count_bound, 1'b1, n_r <= dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS))
  `DTQ_ASSERT_NEXT(a_start_answers, accept && (in_ch.req_type != dtq_pkg::REQ_TICK),
                   out_valid_r && out_last_r && !out_fired_r)
endmodule
`default_nettype wire

// ===== sim/tb_deadline_timer_queue_top.sv =====
// Self-checking testbench of the deadline timer queue: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module tb_deadline_timer_queue_top;
  typedef struct {
    logic                          fired;
    logic [dtq_pkg::ID_W-1:0]      fired_id;
    logic [dtq_pkg::TICK_BITS-1:0] now_tick;
    logic                          last;
  } timer_beat_t;

  logic clk;
  logic rst_n;
  dtq_in_if  req_ch ();
  dtq_out_if res_ch ();

  deadline_timer_queue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  // Shadow copy of the timer table.
  logic [dtq_pkg::TICK_BITS-1:0] shadow_now;
  logic [dtq_pkg::TICK_BITS-1:0] shadow_deadline [dtq_pkg::TIMERS];
  logic                          shadow_armed [dtq_pkg::TIMERS];
  logic [dtq_pkg::SEQ_W-1:0]     shadow_order [dtq_pkg::TIMERS];
  logic [dtq_pkg::SEQ_W-1:0]     shadow_seq;

  timer_beat_t pending_beats[$];
  int  error_count;
  bit  quiet_mode;
  int  sent_requests;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit is_reached(logic [dtq_pkg::TICK_BITS-1:0] now,
                                    logic [dtq_pkg::TICK_BITS-1:0] dl);
    logic [dtq_pkg::TICK_BITS-1:0] late;
    late = now - dl;
    return late < dtq_pkg::HALF_RANGE;
  endfunction

  // Applies one request to the shadow table and queues the beats it causes.
  task automatic predict_request(logic [dtq_pkg::REQ_W-1:0] req,
                                 logic [dtq_pkg::ID_W-1:0] id,
                                 logic [dtq_pkg::DUR_W-1:0] dur);
    timer_beat_t b;
    int n;
    int best;
    logic [dtq_pkg::TICK_BITS-1:0] best_late, late;
    logic [dtq_pkg::SEQ_W-1:0] best_age, age;
    n = 0;
    if (req == dtq_pkg::REQ_START) begin
      shadow_deadline[id] = shadow_now + {1'b0, dur};
      shadow_armed[id] = 1'b1;
      shadow_order[id] = shadow_seq;
      shadow_seq = shadow_seq + 1;
    end else if (req == dtq_pkg::REQ_STOP) begin
      shadow_armed[id] = 1'b0;
    end else if (req == dtq_pkg::REQ_TICK) begin
      shadow_now = shadow_now + 1;
      while (n < dtq_pkg::MAX_RESULTS) begin
        best = -1;
        best_late = '0;
        best_age = '0;
        for (int i = 0; i < dtq_pkg::TIMERS; i++) begin
          if (shadow_armed[i] && is_reached(shadow_now, shadow_deadline[i])) begin
            late = shadow_now - shadow_deadline[i];
            age = shadow_seq - shadow_order[i];
            if (best < 0 || late > best_late || (late == best_late && age > best_age)) begin
              best = i;
              best_late = late;
              best_age = age;
            end
          end
        end
        if (best < 0) break;
        shadow_armed[best] = 1'b0;
        b.fired = 1'b1;
        b.fired_id = best[dtq_pkg::ID_W-1:0];
        b.now_tick = shadow_now;
        b.last = 1'b0;
        pending_beats.push_back(b);
        n++;
      end
      if (n > 0) pending_beats[pending_beats.size()-1].last = 1'b1;
    end
    if (n == 0) begin
      b.fired = 1'b0;
      b.fired_id = '0;
      b.now_tick = shadow_now;
      b.last = 1'b1;
      pending_beats.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Sends one request beat, with a random idle gap unless quiet_mode is set.
  // Valid stays high into the next beat when no gap follows.
  task automatic send_request(logic [dtq_pkg::REQ_W-1:0] req,
                              logic [dtq_pkg::ID_W-1:0] id,
                              logic [dtq_pkg::DUR_W-1:0] dur);
    while (!quiet_mode && $urandom_range(99) < 14) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req;
    req_ch.timer_id <= id;
    req_ch.duration <= dur;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_request(req, id, dur);
    sent_requests++;
  endtask

  // Result side: random back-pressure and checking against the oldest expectation.
  always @(posedge clk) begin
    timer_beat_t exp_b;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          exp_b = pending_beats.pop_front();
          if (res_ch.fired !== exp_b.fired)
            report_mismatch($sformatf("fired %b exp %b", res_ch.fired, exp_b.fired));
          if (res_ch.fired_id !== exp_b.fired_id)
            report_mismatch($sformatf("fired_id %0d exp %0d", res_ch.fired_id,
                                      exp_b.fired_id));
          if (res_ch.now_tick !== exp_b.now_tick)
            report_mismatch($sformatf("now_tick %h exp %h", res_ch.now_tick,
                                      exp_b.now_tick));
          if (res_ch.last !== exp_b.last)
            report_mismatch($sformatf("last %b exp %b", res_ch.last, exp_b.last));
        end
      end
      res_ch.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_start_stop_basics();
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_START, 4'd0, 31'd0);
    send_request(dtq_pkg::REQ_START, 4'd15, 31'd1);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_STOP, 4'd3, '0);
    send_request(dtq_pkg::REQ_START, 4'd3, 31'd2);
    send_request(dtq_pkg::REQ_STOP, 4'd3, '0);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_RSVD, 4'd9, 31'h7fffffff);
  endtask

  task automatic test_rearm_and_ties();
    send_request(dtq_pkg::REQ_START, 4'd5, 31'd3);
    send_request(dtq_pkg::REQ_START, 4'd5, 31'd1);
    send_request(dtq_pkg::REQ_START, 4'd7, 31'd1);
    send_request(dtq_pkg::REQ_START, 4'd2, 31'd1);
    send_request(dtq_pkg::REQ_START, 4'd9, 31'h7fffffff);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
  endtask

  task automatic test_all_expire();
    for (int i = 0; i < dtq_pkg::TIMERS; i++)
      send_request(dtq_pkg::REQ_START, i[dtq_pkg::ID_W-1:0], 31'd0);
    send_request(dtq_pkg::REQ_TICK, 4'd0, '0);
  endtask

  task automatic test_random_traffic(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      quiet_mode = (k >= count / 3 && k < count / 2);
      r = $urandom_range(99);
      if (r < 40)
        send_request(dtq_pkg::REQ_TICK, dtq_pkg::ID_W'($urandom()),
                     dtq_pkg::DUR_W'($urandom()));
      else if (r < 75)
        send_request(dtq_pkg::REQ_START, dtq_pkg::ID_W'($urandom()),
                     ($urandom_range(9) == 0) ? dtq_pkg::DUR_W'($urandom())
                                              : dtq_pkg::DUR_W'($urandom_range(6)));
      else if (r < 95)
        send_request(dtq_pkg::REQ_STOP, dtq_pkg::ID_W'($urandom()),
                     dtq_pkg::DUR_W'($urandom()));
      else
        send_request(dtq_pkg::REQ_RSVD, dtq_pkg::ID_W'($urandom()),
                     dtq_pkg::DUR_W'($urandom()));
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    quiet_mode = 1'b0;
    error_count = 0;
    sent_requests = 0;
    req_ch.valid = 1'b0;
    req_ch.req_type = dtq_pkg::REQ_TICK;
    req_ch.timer_id = '0;
    req_ch.duration = '0;
    shadow_now = '0;
    shadow_seq = '0;
    for (int i = 0; i < dtq_pkg::TIMERS; i++) begin
      shadow_armed[i] = 1'b0;
      shadow_deadline[i] = '0;
      shadow_order[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_start_stop_basics();
    test_rearm_and_ties();
    test_all_expire();
    test_random_traffic(190);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (400) @(posedge clk);
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
